### hw/rtl/mfa_pkg.sv
// ----------------------------------------------------------------------------
// mfa_pkg
// Shared types, constants and helpers of the metaball field accumulator.
// ----------------------------------------------------------------------------
package mfa_pkg;

  // configuration register indexes
  localparam logic CFG_ALPHA  = 1'b0;
  localparam logic CFG_THRESH = 1'b1;

  localparam logic [15:0] ALPHA_RESET = 16'd4096;

  // divider sizes
  localparam int DivQw = 35;
  localparam int DivCw = 6;

  // one sphere as it travels from the front to the back
  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] dz;
    logic [15:0]        radius;
    logic               last;
  } item_t;

  // divider request
  typedef struct packed {
    logic              start;
    logic [31:0]       rem0;
    logic [DivQw-1:0]  bits;
    logic [DivCw-1:0]  count;
    logic [31:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic [31:0] val;
    logic        clip;
  } sat_t;

  // saturating add of a wide signed term into a 32-bit accumulator
  function automatic sat_t sat_add(logic signed [31:0] acc, logic signed [44:0] add);
    logic signed [44:0] sum;
    sat_t res;
    sum = 45'(acc) + add;
    res.clip = 1'b0;
    res.val  = sum[31:0];
    if (sum > 45'sd2147483647) begin
      res.val  = 32'h7FFF_FFFF;
      res.clip = 1'b1;
    end else if (sum < -45'sd2147483648) begin
      res.val  = 32'h8000_0000;
      res.clip = 1'b1;
    end
    return res;
  endfunction

endpackage

### hw/rtl/mfa_front.sv
// ----------------------------------------------------------------------------
// mfa_front
// Accepts sphere items, forms the offset to the query point, and holds them
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module mfa_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  query_x_i,
  input  logic signed [15:0]  query_y_i,
  input  logic signed [15:0]  query_z_i,
  input  logic signed [15:0]  center_x_i,
  input  logic signed [15:0]  center_y_i,
  input  logic signed [15:0]  center_z_i,
  input  logic [15:0]         sphere_radius_i,
  input  logic                last_sphere_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output mfa_pkg::item_t      q_item_o
);
  import mfa_pkg::*;

  item_t      mem_q [2];
  item_t      wr_item;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  // offset of the query point from the center
  always_comb begin
    wr_item.dx     = 17'(query_x_i) - 17'(center_x_i);
    wr_item.dy     = 17'(query_y_i) - 17'(center_y_i);
    wr_item.dz     = 17'(query_z_i) - 17'(center_z_i);
    wr_item.radius = sphere_radius_i;
    wr_item.last   = last_sphere_i;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

### hw/rtl/mfa_div.sv
// ----------------------------------------------------------------------------
// mfa_div
// Restoring divider, one quotient bit per cycle; dividend bits enter msb
// first after a preloaded partial remainder.
// ----------------------------------------------------------------------------
module mfa_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mfa_pkg::div_req_t        req_i,
  output logic                     done_o,
  output logic [mfa_pkg::DivQw-1:0] quot_o
);
  import mfa_pkg::*;

  logic [31:0]      rem_q, dsr_q;
  logic [DivQw-1:0] bits_q, quot_q;
  logic [DivCw-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [32:0]      trial;
  logic             ge;

  // one restoring step
  assign trial = {rem_q, bits_q[DivQw-1]};
  assign ge    = (trial >= {1'b0, dsr_q});

  // iteration registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem0;
      bits_q <= req_i.bits;
      dsr_q  <= req_i.divisor;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
      bits_q <= {bits_q[DivQw-2:0], 1'b0};
      quot_q <= {quot_q[DivQw-2:0], ge};
    end
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DivCw'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.count;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivCw'(1);
        if (cnt_q == DivCw'(1)) busy_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### hw/rtl/mfa_back.sv
// ----------------------------------------------------------------------------
// mfa_back
// Sequencer that evaluates one sphere's field and gradient terms with a
// shared multiplier and divider, keeps the accumulators and the result.
// ----------------------------------------------------------------------------
module mfa_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  mfa_pkg::item_t      q_item_i,
  input  logic [15:0]         alpha_scale_i,
  input  logic signed [31:0]  iso_threshold_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  field_value_o,
  output logic signed [31:0]  grad_x_o,
  output logic signed [31:0]  grad_y_o,
  output logic signed [31:0]  grad_z_o,
  output logic                saturated_o
);
  import mfa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MA, ST_MX, ST_MY, ST_MZ, ST_CHK, ST_D1, ST_S,
    ST_FI, ST_R2, ST_D2, ST_GX, ST_GY, ST_GZ, ST_AZ, ST_FIN
  } state_e;

  state_e             state_q;
  item_t              it_q;
  logic [31:0]        a_q;
  logic [33:0]        r_q;
  logic [16:0]        s_q, fi_q;
  logic [DivQw-1:0]   dfi_q;
  logic [51:0]        prod_q;
  logic [34:0]        mul_a;
  logic [16:0]        mul_b;
  logic signed [31:0] acc_v_q, acc_x_q, acc_y_q, acc_z_q;
  logic               clip_q;
  logic               out_valid_q;
  logic [31:0]        out_v_q, out_x_q, out_y_q, out_z_q;
  logic               out_sat_q;
  logic [16:0]        mx, my, mz;
  logic [33:0]        r_sum;
  logic               skip;
  logic               term_neg;
  logic signed [44:0] term;
  sat_t               acc_sat, fi_sat, fin_sat;
  div_req_t           div_req;
  logic               div_done;
  logic [DivQw-1:0]   div_quot;
  logic               out_free;
  logic               out_load;

  // magnitudes of the offsets
  assign mx = it_q.dx[16] ? 17'(-it_q.dx) : 17'(it_q.dx);
  assign my = it_q.dy[16] ? 17'(-it_q.dy) : 17'(it_q.dy);
  assign mz = it_q.dz[16] ? 17'(-it_q.dz) : 17'(it_q.dz);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MA:        begin mul_a = 35'(alpha_scale_i); mul_b = 17'(it_q.radius); end
      ST_MX:        begin mul_a = 35'(mx); mul_b = mx; end
      ST_MY:        begin mul_a = 35'(my); mul_b = my; end
      ST_MZ:        begin mul_a = 35'(mz); mul_b = mz; end
      ST_D1:        begin mul_a = 35'(div_quot[16:0]); mul_b = div_quot[16:0]; end
      ST_S:         begin
        mul_a = 35'(17'((33'h1_0000_0000 - prod_q[32:0]) >> 16));
        mul_b = 17'((33'h1_0000_0000 - prod_q[32:0]) >> 16);
      end
      ST_FI:        begin mul_a = 35'(it_q.radius); mul_b = 17'(it_q.radius); end
      ST_GX:        begin mul_a = dfi_q; mul_b = mx; end
      ST_GY:        begin mul_a = dfi_q; mul_b = my; end
      ST_GZ:        begin mul_a = dfi_q; mul_b = mz; end
      default:      begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // squared distance and the influence test
  assign r_sum = r_q + prod_q[33:0];
  assign skip  = (it_q.radius == 16'd0) || (a_q == 32'd0) ||
                 ({r_sum, 4'b0} > {6'b0, a_q});

  // divider requests: r over Ri, then the gradient scale
  always_comb begin
    div_req       = '0;
    div_req.start = 1'b0;
    if (state_q == ST_CHK && !skip) begin
      div_req.start   = 1'b1;
      div_req.rem0    = 32'({r_sum, 3'b0});
      div_req.bits    = '0;
      div_req.count   = DivCw'(17);
      div_req.divisor = a_q;
    end else if (state_q == ST_R2) begin
      div_req.start   = 1'b1;
      div_req.rem0    = '0;
      div_req.bits    = {s_q, 18'b0};
      div_req.count   = DivCw'(DivQw);
      div_req.divisor = prod_q[31:0];
    end
  end

  mfa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // gradient term, truncated toward zero
  always_comb begin
    unique case (state_q)
      ST_GY:   term_neg = it_q.dx[16];
      ST_GZ:   term_neg = it_q.dy[16];
      default: term_neg = it_q.dz[16];
    endcase
    term = term_neg ? -45'(prod_q[51:8]) : 45'(prod_q[51:8]);
  end

  always_comb begin
    unique case (state_q)
      ST_GY:   acc_sat = sat_add(acc_x_q, term);
      ST_GZ:   acc_sat = sat_add(acc_y_q, term);
      default: acc_sat = sat_add(acc_z_q, term);
    endcase
  end

  assign fi_sat   = sat_add(acc_v_q, 45'(fi_q));
  assign fin_sat  = sat_add(acc_v_q, -45'(iso_threshold_i));
  assign out_free = !out_valid_q || out_ready_i;
  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;

  // result register loads on the last sphere once the output is free
  assign out_load = (state_q == ST_FIN) && it_q.last && out_free;

  // sequencer, datapath and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_v_q     <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      acc_z_q     <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      prod_q <= 52'(mul_a * 52'(mul_b));
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            it_q    <= q_item_i;
            state_q <= ST_MA;
          end
        end
        ST_MA:  state_q <= ST_MX;
        ST_MX:  begin a_q <= prod_q[31:0]; state_q <= ST_MY; end
        ST_MY:  begin r_q <= 34'(prod_q[33:0]); state_q <= ST_MZ; end
        ST_MZ:  begin r_q <= r_sum; state_q <= ST_CHK; end
        ST_CHK: state_q <= skip ? ST_FIN : ST_D1;
        ST_D1:  if (div_done) state_q <= ST_S;
        ST_S: begin
          s_q     <= 17'((33'h1_0000_0000 - prod_q[32:0]) >> 16);
          state_q <= ST_FI;
        end
        ST_FI:  begin fi_q <= prod_q[32:16]; state_q <= ST_R2; end
        ST_R2:  state_q <= ST_D2;
        ST_D2: begin
          if (div_done) begin
            dfi_q   <= div_quot;
            state_q <= ST_GX;
          end
        end
        ST_GX:  state_q <= ST_GY;
        ST_GY: begin
          acc_x_q <= acc_sat.val;
          clip_q  <= clip_q | acc_sat.clip;
          state_q <= ST_GZ;
        end
        ST_GZ: begin
          acc_y_q <= acc_sat.val;
          clip_q  <= clip_q | acc_sat.clip;
          state_q <= ST_AZ;
        end
        ST_AZ: begin
          acc_z_q <= acc_sat.val;
          acc_v_q <= fi_sat.val;
          clip_q  <= clip_q | acc_sat.clip | fi_sat.clip;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!it_q.last) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_v_q     <= fin_sat.val;
            out_x_q     <= acc_x_q;
            out_y_q     <= acc_y_q;
            out_z_q     <= acc_z_q;
            out_sat_q   <= clip_q | fin_sat.clip;
            acc_v_q     <= '0;
            acc_x_q     <= '0;
            acc_y_q     <= '0;
            acc_z_q     <= '0;
            clip_q      <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign field_value_o = out_v_q;
  assign grad_x_o      = out_x_q;
  assign grad_y_o      = out_y_q;
  assign grad_z_o      = out_z_q;
  assign saturated_o   = out_sat_q;

endmodule

### hw/rtl/metaball_field_accumulator_unit.sv
// ----------------------------------------------------------------------------
// metaball_field_accumulator_unit
// Metaball implicit field and gradient accumulator over sphere items.
//
//   channel   direction  handshake              payload
//   in        input      in_valid/in_ready      query, center, radius, last
//   cfg       input      cfg_valid/cfg_ready    cfg_index, cfg_data
//   out       output     out_valid/out_ready    field value, gradient, flag
//
// A sphere inside its bound takes the longest path, through the shared
// bit-serial divider (17 steps for r over Ri, 35 for the gradient scale).
// A sphere outside its bound or with zero radius skips the divider.
// A two-entry queue lets the input keep accepting while the back works.
// Reset clears accumulators, threshold and queue, and sets alpha to ALPHA_RESET.
// ----------------------------------------------------------------------------
module metaball_field_accumulator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] query_x_i,
  input  logic signed [15:0] query_y_i,
  input  logic signed [15:0] query_z_i,
  input  logic signed [15:0] center_x_i,
  input  logic signed [15:0] center_y_i,
  input  logic signed [15:0] center_z_i,
  input  logic [15:0]        sphere_radius_i,
  input  logic               last_sphere_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] field_value_o,
  output logic signed [31:0] grad_x_o,
  output logic signed [31:0] grad_y_o,
  output logic signed [31:0] grad_z_o,
  output logic               saturated_o
);
  import mfa_pkg::*;

  logic [15:0]        alpha_q;
  logic signed [31:0] thresh_q;
  logic               q_valid, q_pop;
  item_t              q_item;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= ALPHA_RESET;
      thresh_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ALPHA:  alpha_q  <= cfg_data_i[15:0];
        CFG_THRESH: thresh_q <= cfg_data_i;
        default:    alpha_q  <= alpha_q;
      endcase
    end
  end

  mfa_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .query_x_i       (query_x_i),
    .query_y_i       (query_y_i),
    .query_z_i       (query_z_i),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .center_z_i      (center_z_i),
    .sphere_radius_i (sphere_radius_i),
    .last_sphere_i   (last_sphere_i),
    .q_valid_o       (q_valid),
    .q_pop_i         (q_pop),
    .q_item_o        (q_item)
  );

  mfa_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_pop_o         (q_pop),
    .q_item_i        (q_item),
    .alpha_scale_i   (alpha_q),
    .iso_threshold_i (thresh_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .field_value_o   (field_value_o),
    .grad_x_o        (grad_x_o),
    .grad_y_o        (grad_y_o),
    .grad_z_o        (grad_z_o),
    .saturated_o     (saturated_o)
  );

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// metaball field accumulator testbench
// Sends sphere items for query points, predicts the summed field, its
// gradient and the clip flag per query, and checks each result in order.
// Covers directed corner cases, register extremes, random queries under
// random idling, and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mfa_pkg::*;

  localparam longint CycleLimit = 2000000;
  localparam int     DrainCycles = 200;

  typedef struct {
    logic signed [15:0] qx, qy, qz;
    logic signed [15:0] cx, cy, cz;
    logic [15:0]        rad;
    logic               last;
  } sphere_t;

  typedef struct {
    logic signed [31:0] value, gx, gy, gz;
    logic               clip;
  } field_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] query_x_i = '0, query_y_i = '0, query_z_i = '0;
  logic signed [15:0] center_x_i = '0, center_y_i = '0, center_z_i = '0;
  logic [15:0] sphere_radius_i = '0;
  logic last_sphere_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = CFG_ALPHA;
  logic [31:0] cfg_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] field_value_o, grad_x_o, grad_y_o, grad_z_o;
  logic saturated_o;

  // predictor state
  logic [15:0]        alpha_q412 = ALPHA_RESET;
  logic signed [31:0] iso_level = '0;
  logic signed [31:0] sum_value = '0, sum_gx = '0, sum_gy = '0, sum_gz = '0;
  logic               sum_clipped = 1'b0;
  field_t             pending_fields[$];

  int     error_count = 0;
  int     spheres_sent = 0;
  int     fields_checked = 0;
  longint cycle_count = 0;
  logic   hold_output = 1'b0;
  logic   calm = 1'b0;
  int     rx_wait = 0;

  metaball_field_accumulator_unit i_dut (.*);

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results pending", $time, pending_fields.size());
      $display("metaball_field_accumulator_unit test failed");
      $finish;
    end
  end

  // idle length: mostly short, sometimes long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (calm) return 0;
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // saturating accumulate
  function automatic logic signed [31:0] clip_add(logic signed [31:0] acc, longint term);
    longint total;
    total = longint'(acc) + term;
    if (total > 64'sd2147483647) begin
      sum_clipped = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (total < -64'sd2147483648) begin
      sum_clipped = 1'b1;
      return 32'sh8000_0000;
    end
    return total[31:0];
  endfunction

  // dfi * d / 256, truncated toward zero
  function automatic longint slope_term(longint unsigned dfi, int d);
    longint unsigned mag;
    longint t;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    t = longint'((dfi * mag) >> 8);
    return (d < 0) ? -t : t;
  endfunction

  // field contribution of one accepted sphere, result on the last one
  function automatic void predict_sphere(sphere_t s);
    int dx, dy, dz;
    longint unsigned bound, dist2, q, rem, fi, dfi;
    field_t res;
    dx = int'(s.qx) - int'(s.cx);
    dy = int'(s.qy) - int'(s.cy);
    dz = int'(s.qz) - int'(s.cz);
    bound = longint'(alpha_q412) * longint'(s.rad);
    dist2 = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy) +
            longint'(dz) * longint'(dz);
    if (s.rad != 0 && bound != 0 && dist2 * 16 <= bound) begin
      q   = ((dist2 * 16) << 16) / bound;
      rem = ((64'd1 << 32) - q * q) >> 16;
      fi  = (rem * rem) >> 16;
      dfi = (rem << 18) / (longint'(s.rad) * longint'(s.rad));
      sum_value = clip_add(sum_value, longint'(fi));
      sum_gx = clip_add(sum_gx, slope_term(dfi, dx));
      sum_gy = clip_add(sum_gy, slope_term(dfi, dy));
      sum_gz = clip_add(sum_gz, slope_term(dfi, dz));
    end
    if (s.last) begin
      res.value = clip_add(sum_value, -longint'(iso_level));
      res.gx = sum_gx;
      res.gy = sum_gy;
      res.gz = sum_gz;
      res.clip = sum_clipped;
      pending_fields.insert(pending_fields.size(), res);
      sum_value = '0;
      sum_gx = '0;
      sum_gy = '0;
      sum_gz = '0;
      sum_clipped = 1'b0;
    end
  endfunction

  // send one sphere item
  task automatic send_sphere(sphere_t s);
    repeat (pick_gap()) @(negedge clk_i);
    in_valid_i = 1'b1;
    query_x_i = s.qx;
    query_y_i = s.qy;
    query_z_i = s.qz;
    center_x_i = s.cx;
    center_y_i = s.cy;
    center_z_i = s.cz;
    sphere_radius_i = s.rad;
    last_sphere_i = s.last;
    @(posedge clk_i iff in_ready_o);
    predict_sphere(s);
    spheres_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // register write, block is idle
  task automatic write_reg(logic idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i iff cfg_ready_o);
    if (idx == CFG_ALPHA) alpha_q412 = data[15:0];
    else iso_level = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    wait (pending_fields.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic sphere_t mk(int qx, int qy, int qz, int cx, int cy, int cz,
                                 int rad, bit last);
    sphere_t s;
    s.qx = 16'(qx); s.qy = 16'(qy); s.qz = 16'(qz);
    s.cx = 16'(cx); s.cy = 16'(cy); s.cz = 16'(cz);
    s.rad = 16'(rad); s.last = last;
    return s;
  endfunction

  // random sphere, mostly near the query point so it lands inside its bound
  function automatic sphere_t rand_sphere(int qx, int qy, int qz, bit last);
    sphere_t s;
    int roll, k;
    roll = $urandom_range(99);
    s.qx = 16'(qx); s.qy = 16'(qy); s.qz = 16'(qz); s.last = last;
    if (roll < 12) begin
      s.cx = 16'($urandom); s.cy = 16'($urandom); s.cz = 16'($urandom);
      s.rad = 16'($urandom);
      s.qx = 16'($urandom);
    end else begin
      k = $urandom_range(0, 11);
      s.cx = 16'(qx - $signed($urandom_range(0, 2 << k)) + (1 << k));
      s.cy = 16'(qy - $signed($urandom_range(0, 2 << k)) + (1 << k));
      s.cz = 16'(qz - $signed($urandom_range(0, 2 << k)) + (1 << k));
      roll = $urandom_range(99);
      if (roll < 8) s.rad = '0;
      else if (roll < 25) s.rad = 16'($urandom_range(1, 255));
      else if (roll < 85) s.rad = 16'($urandom_range(256, 8191));
      else s.rad = 16'($urandom_range(8192, 65535));
    end
    return s;
  endfunction

  // one query of n random spheres
  task automatic send_query(int n);
    int qx, qy, qz;
    qx = $signed($urandom_range(0, 32767)) - 16384;
    qy = $signed($urandom_range(0, 32767)) - 16384;
    qz = $signed($urandom_range(0, 32767)) - 16384;
    for (int i = 0; i < n; i++) send_sphere(rand_sphere(qx, qy, qz, i == n - 1));
  endtask

  // receiver with random stalls
  always @(negedge clk_i) begin
    if (hold_output) begin
      out_ready_i = 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = 1'b1;
      rx_wait = pick_gap();
    end
  end

  // result checker
  always @(posedge clk_i) begin
    field_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_fields.size() == 0) begin
        $display("%0t: unexpected result value=%h", $time, field_value_o);
        error_count++;
      end else begin
        e = pending_fields.pop_front();
        fields_checked++;
        if (field_value_o !== e.value) begin
          $display("%0t: field_value exp %h got %h", $time, e.value, field_value_o);
          error_count++;
        end
        if (grad_x_o !== e.gx) begin
          $display("%0t: grad_x exp %h got %h", $time, e.gx, grad_x_o);
          error_count++;
        end
        if (grad_y_o !== e.gy) begin
          $display("%0t: grad_y exp %h got %h", $time, e.gy, grad_y_o);
          error_count++;
        end
        if (grad_z_o !== e.gz) begin
          $display("%0t: grad_z exp %h got %h", $time, e.gz, grad_z_o);
          error_count++;
        end
        if (saturated_o !== e.clip) begin
          $display("%0t: saturated exp %b got %b", $time, e.clip, saturated_o);
          error_count++;
        end
      end
    end
  end

  // corner cases at reset settings
  task automatic test_directed();
    send_sphere(mk(0, 0, 0, 0, 0, 0, 256, 1));                   // at the center
    send_sphere(mk(100, -50, 7, 100, -50, 7, 0, 1));             // zero radius
    send_sphere(mk(32767, 32767, 32767, -32768, -32768, -32768, 65535, 1)); // far
    send_sphere(mk(-32768, -32768, -32768, 32767, 32767, 32767, 65535, 0));
    send_sphere(mk(0, 0, 0, 0, 0, 0, 65535, 1));                 // max radius
    send_sphere(mk(40, -40, 20, 0, 0, 0, 1, 0));                 // tiny radius, big slope
    send_sphere(mk(40, -40, 20, 0, 0, 0, 1, 0));
    send_sphere(mk(40, -40, 20, 0, 0, 0, 1, 1));
    send_sphere(mk(-40, 40, -20, 0, 0, 0, 1, 0));
    send_sphere(mk(-40, 40, -20, 0, 0, 0, 1, 1));
    send_sphere(mk(300, 0, 0, 0, 0, 0, 4096, 0));                // several spheres
    send_sphere(mk(300, 0, 0, 600, 0, 0, 4096, 0));
    send_sphere(mk(300, 0, 0, 300, -256, 128, 2048, 0));
    send_sphere(mk(300, 0, 0, 300, 0, 0, 0, 1));                 // zero radius last
    send_sphere(mk(64, 0, 0, 0, 0, 0, 1024, 1));                 // well inside the bound
    send_sphere(mk(65, 0, 0, 0, 0, 0, 1024, 1));                 // one step farther out, still inside
    wait_drained();
  endtask

  // register extremes
  task automatic test_registers();
    write_reg(CFG_ALPHA, 32'd0);
    send_sphere(mk(0, 0, 0, 0, 0, 0, 256, 1));
    wait_drained();
    write_reg(CFG_ALPHA, 32'hFFFF_FFFF);
    write_reg(CFG_THRESH, 32'h8000_0000);
    send_sphere(mk(0, 0, 0, 0, 0, 0, 0, 1));                     // final clip
    send_sphere(mk(1000, 0, 0, 0, 0, 0, 512, 1));
    wait_drained();
    write_reg(CFG_THRESH, 32'h7FFF_FFFF);
    send_sphere(mk(0, 0, 0, 0, 0, 0, 256, 1));
    send_query(3);
    wait_drained();
    write_reg(CFG_THRESH, 32'hFFFF_0000);
    write_reg(CFG_ALPHA, 32'h0000_1000);
    send_query(2);
    wait_drained();
  endtask

  // random queries over several settings
  task automatic test_random();
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(CFG_ALPHA, (phase == 0) ? 32'd4096 : $urandom);
      write_reg(CFG_THRESH, (phase == 1) ? 32'h8000_0001 : $urandom_range(0, 32'h3_0000));
      calm = (phase == 3);
      for (int i = 0; i < 70; i++) send_query($urandom_range(1, 5));
      wait_drained();
    end
    calm = 1'b0;
  endtask

  // long output stall so the block fills up, then drain
  task automatic test_backpressure();
    write_reg(CFG_ALPHA, 32'd4096);
    write_reg(CFG_THRESH, 32'd0);
    fork
      begin
        hold_output = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_output = 1'b0;
      end
    join_none
    for (int i = 0; i < 20; i++) send_query(2);
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_registers();
    test_backpressure();
    test_random();
    wait_drained();
    $display("covered %0d sphere items and %0d field results over register sweeps",
             spheres_sent, fields_checked);
    if (error_count == 0) begin
      $display("metaball_field_accumulator_unit test passed");
    end else begin
      $display("metaball_field_accumulator_unit test failed");
    end
    $finish;
  end

endmodule
